@@ design/lgs_pkg.sv @@
// ----------------------------------------------------------------------------
// lgs_pkg: shared types and constants of the LDA Gibbs topic sampler
// Widths of the count stores and the arithmetic, sequencer states, step-unit
// operations and configuration register indexes.
// ----------------------------------------------------------------------------
package lgs_pkg;

	localparam int unsigned TOPIC_W    = 6;
	localparam int unsigned KUSE_W     = 7;
	localparam int unsigned WORD_W     = 14;
	localparam int unsigned DOC_W      = 10;
	localparam int unsigned SLOT_W     = 18;
	localparam int unsigned CNT_W      = 19;
	localparam int unsigned FRAC_W     = 32;
	localparam int unsigned OPND_W     = 36;
	localparam int unsigned VBETA_W    = 39;
	localparam int unsigned TOTAL_W    = 38;
	localparam int unsigned DEN_W      = 40;
	localparam int unsigned NUM_W      = 52;
	localparam int unsigned ACC_W      = 49;
	localparam int unsigned STEP_W     = 6;
	localparam int unsigned TWC_AW     = 20;
	localparam int unsigned DTC_AW     = 16;
	localparam int unsigned MAX_TOPICS = 64;
	localparam int unsigned MAX_DOCS   = 1024;
	localparam int unsigned MAX_TOKENS = 262144;
	localparam int unsigned TWC_DEPTH  = 1048576;
	localparam int unsigned DTC_DEPTH  = 65536;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 24;
	localparam int unsigned S_DATA_W   = 80;
	localparam int unsigned M_DATA_W   = 8;

	localparam logic [CNT_W-1:0] COUNT_MAX = '1;
	localparam logic [ACC_W-1:0] ACC_SAT   = {1'b1, 48'd0};
	localparam logic [STEP_W-1:0] DIV_STEPS_M1 = 6'd51;
	localparam logic [STEP_W-1:0] FRAC_STEPS_M1 = 6'd31;

	localparam logic OP_INIT     = 1'b0;
	localparam logic OP_RESAMPLE = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_TOPIC_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VOCAB_SIZE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHA       = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BETA        = 2'd3;

	localparam logic [KUSE_W-1:0]     RST_TOPIC_COUNT = 7'd64;
	localparam logic [WORD_W:0]       RST_VOCAB_SIZE  = 15'd16384;
	localparam logic [CFG_DATA_W-1:0] RST_ALPHA       = 24'd51200;
	localparam logic [CFG_DATA_W-1:0] RST_BETA        = 24'd6554;

	typedef enum logic [1:0] {
		STEP_DIV,
		STEP_MUL,
		STEP_RSH
	} step_op_t;

	typedef struct packed {
		step_op_t          op;
		logic              in_bit;
		logic [ACC_W-1:0]  acc;
		logic [DEN_W-1:0]  rem;
		logic [DEN_W-1:0]  operand;
	} step_req_t;

	typedef struct packed {
		logic [ACC_W-1:0]  acc;
		logic [DEN_W-1:0]  rem;
		logic              q_bit;
	} step_res_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_TOK_RD,
		ST_TOK_LD,
		ST_DEC_RD,
		ST_DEC_WR,
		ST_W_RD,
		ST_W_LD,
		ST_DIV,
		ST_MUL,
		ST_W_ACC,
		ST_FRAC,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_INC_RD,
		ST_INC_WR,
		ST_DONE
	} lgs_state_t;

endpackage

@@ design/lda_gibbs_topic_sampler.sv @@
// ----------------------------------------------------------------------------
// lda_gibbs_topic_sampler: collapsed Gibbs topic sampler for LDA
// Keeps the token, word-topic, document-topic and topic totals and assigns
// or resamples the topic of one corpus token per input transaction.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the count memories and
// accepts no input during that time; configuration writes are taken only
// while the block is idle with no result waiting, and take precedence over
// an input transaction offered in the same cycle. An init transaction runs
// the threshold scaling and then the count update and output. A resample
// transaction passes every topic weight through one shared bit-serial step
// unit: the Q36.16 ratio division and the multiply by the document term,
// with read, load and accumulation states around them (a topic with a zero
// denominator skips the divide and multiply), followed by the threshold
// scaling and a scan of the stored cumulative weights, one read and one
// compare per topic, that stops at the drawn topic. One transaction is
// processed at a time; a finished result waits in the output register while
// the next input transaction is accepted, and a result that is still unread
// when the next one finishes holds the block.
module lda_gibbs_topic_sampler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// doc_index[9:0], token_slot[27:10], word_id[41:28], random_fraction[73:42], zero pad
	input  logic [79:0] s_tdata,
	// operation (0 init, 1 resample)
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// topic[5:0], zero pad
	output logic [7:0]  m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	lgs_pkg::lgs_state_t state_q, state_d;

	logic [19:0] clr_q;
	logic [6:0]  topic_count_q;
	logic [14:0] vocab_q;
	logic [23:0] alpha_q;
	logic [23:0] beta_q;
	logic [6:0]  k_use;

	logic        op_q;
	logic [9:0]  doc_q;
	logic [17:0] slot_q;
	logic [13:0] word_q;
	logic [31:0] frac_q;
	logic [5:0]  topic_q;
	logic [6:0]  k_q;
	logic [5:0]  cnt_q;
	logic [51:0] num_q;
	logic [39:0] rem_q;
	logic [48:0] acc_q;
	logic [35:0] b_q;
	logic [39:0] den_q;
	logic [38:0] vbeta_q;
	logic [37:0] total_q;
	logic        m_tvalid_q;
	logic [5:0]  m_topic_q;

	lgs_pkg::step_req_t step_req;
	lgs_pkg::step_res_t step_res;

	logic [5:0]  tok_rd;
	logic [18:0] twc_rd, dtc_rd, dt_rd, tt_rd;
	logic [37:0] cum_rd;

	logic        clearing, upd_we, up;
	logic [5:0]  rd_topic;
	logic        twc_we, dtc_we, dt_we, tt_we;
	logic [19:0] twc_waddr;
	logic [15:0] dtc_waddr;
	logic [9:0]  dt_waddr;
	logic [5:0]  tt_waddr;
	logic [18:0] twc_wdata, dtc_wdata, dt_wdata, tt_wdata;

	logic [35:0] a_w, b_w;
	logic [39:0] den_w;
	logic [31:0] weight;
	logic [37:0] total_next;
	logic        k_last, out_free, hit;

	function automatic logic [18:0] cnt_upd(input logic [18:0] c, input logic inc);
		logic [18:0] r;
		if (inc) begin
			r = (c == lgs_pkg::COUNT_MAX) ? c : c + 19'd1;
		end else begin
			r = (c == 19'd0) ? c : c - 19'd1;
		end
		return r;
	endfunction

	// Topic count as used: zero acts as one, anything above 64 as 64.
	always_comb begin
		if (topic_count_q == 7'd0) begin
			k_use = 7'd1;
		end else if (topic_count_q > 7'(lgs_pkg::MAX_TOPICS)) begin
			k_use = 7'(lgs_pkg::MAX_TOPICS);
		end else begin
			k_use = topic_count_q;
		end
	end

	// Configuration is only taken with nothing in flight, and wins over an
	// input transaction offered in the same cycle.
	assign cfg_ready = (state_q == lgs_pkg::ST_IDLE) && !m_tvalid_q;
	assign s_tready  = (state_q == lgs_pkg::ST_IDLE) && !(cfg_valid && cfg_ready);
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = {2'b00, m_topic_q};
	assign out_free  = !m_tvalid_q || m_tready;

	// Per-topic operands of the weight (nw+beta)(nd+alpha)/(nt+V*beta).
	assign a_w   = 36'({twc_rd, 16'd0}) + 36'(beta_q);
	assign b_w   = 36'({dtc_rd, 16'd0}) + 36'(alpha_q);
	assign den_w = 40'({tt_rd, 16'd0}) + 40'(vbeta_q);

	// A product of 2^48 or more saturates the weight to all ones.
	assign weight     = acc_q[48] ? 32'hFFFF_FFFF : acc_q[47:16];
	assign total_next = total_q + 38'(weight);
	assign k_last     = (k_q + 7'd1) == k_use;
	assign hit        = cum_rd > acc_q[37:0];

	// Shared step unit request.
	always_comb begin
		step_req.op = lgs_pkg::STEP_DIV;
		step_req.in_bit = num_q[51];
		step_req.acc = acc_q;
		step_req.rem = rem_q;
		step_req.operand = den_q;
		unique case (state_q)
			lgs_pkg::ST_MUL: begin
				step_req.op = lgs_pkg::STEP_MUL;
				step_req.operand = 40'(b_q);
			end
			lgs_pkg::ST_FRAC: begin
				step_req.op = lgs_pkg::STEP_RSH;
				step_req.in_bit = frac_q[0];
				step_req.operand = (op_q == lgs_pkg::OP_RESAMPLE) ? 40'(total_q) : 40'(k_use);
			end
			default: begin
			end
		endcase
	end

	lgs_step_unit u_step (
		.req(step_req),
		.res(step_res)
	);

	// Sequencer.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lgs_pkg::ST_CLEAR:    if (clr_q == 20'hF_FFFF) state_d = lgs_pkg::ST_IDLE;
			lgs_pkg::ST_IDLE: begin
				if (s_tvalid && s_tready) begin
					state_d = (s_tuser == lgs_pkg::OP_RESAMPLE) ? lgs_pkg::ST_TOK_RD :
						lgs_pkg::ST_FRAC;
				end
			end
			lgs_pkg::ST_TOK_RD:   state_d = lgs_pkg::ST_TOK_LD;
			lgs_pkg::ST_TOK_LD:   state_d = lgs_pkg::ST_DEC_RD;
			lgs_pkg::ST_DEC_RD:   state_d = lgs_pkg::ST_DEC_WR;
			lgs_pkg::ST_DEC_WR:   state_d = lgs_pkg::ST_W_RD;
			lgs_pkg::ST_W_RD:     state_d = lgs_pkg::ST_W_LD;
			lgs_pkg::ST_W_LD: begin
				state_d = (den_w == 40'd0) ? lgs_pkg::ST_W_ACC : lgs_pkg::ST_DIV;
			end
			lgs_pkg::ST_DIV:      if (cnt_q == 6'd0) state_d = lgs_pkg::ST_MUL;
			lgs_pkg::ST_MUL:      if (cnt_q == 6'd0) state_d = lgs_pkg::ST_W_ACC;
			lgs_pkg::ST_W_ACC:    state_d = k_last ? lgs_pkg::ST_FRAC : lgs_pkg::ST_W_RD;
			lgs_pkg::ST_FRAC: begin
				if (cnt_q == 6'd0) begin
					state_d = (op_q == lgs_pkg::OP_RESAMPLE) ? lgs_pkg::ST_SCAN_RD :
						lgs_pkg::ST_INC_RD;
				end
			end
			lgs_pkg::ST_SCAN_RD:  state_d = lgs_pkg::ST_SCAN_CMP;
			lgs_pkg::ST_SCAN_CMP: begin
				state_d = (hit || k_last) ? lgs_pkg::ST_INC_RD : lgs_pkg::ST_SCAN_RD;
			end
			lgs_pkg::ST_INC_RD:   state_d = lgs_pkg::ST_INC_WR;
			lgs_pkg::ST_INC_WR:   state_d = lgs_pkg::ST_DONE;
			lgs_pkg::ST_DONE:     if (out_free) state_d = lgs_pkg::ST_IDLE;
			default:              state_d = lgs_pkg::ST_IDLE;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lgs_pkg::ST_CLEAR;
			clr_q <= '0;
			m_tvalid_q <= 1'b0;
			topic_count_q <= lgs_pkg::RST_TOPIC_COUNT;
			vocab_q <= lgs_pkg::RST_VOCAB_SIZE;
			alpha_q <= lgs_pkg::RST_ALPHA;
			beta_q <= lgs_pkg::RST_BETA;
		end else begin
			state_q <= state_d;
			if (state_q == lgs_pkg::ST_CLEAR) begin
				clr_q <= clr_q + 20'd1;
			end
			if (state_q == lgs_pkg::ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					lgs_pkg::CFG_TOPIC_COUNT: topic_count_q <= cfg_data[6:0];
					lgs_pkg::CFG_VOCAB_SIZE:  vocab_q <= cfg_data[14:0];
					lgs_pkg::CFG_ALPHA:       alpha_q <= cfg_data;
					lgs_pkg::CFG_BETA:        beta_q <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			lgs_pkg::ST_IDLE: begin
				op_q <= s_tuser;
				doc_q <= s_tdata[9:0];
				slot_q <= s_tdata[27:10];
				word_q <= s_tdata[41:28];
				frac_q <= s_tdata[73:42];
				vbeta_q <= 39'(vocab_q) * 39'(beta_q);
				total_q <= '0;
				k_q <= '0;
				acc_q <= '0;
				cnt_q <= lgs_pkg::FRAC_STEPS_M1;
			end
			lgs_pkg::ST_TOK_LD: topic_q <= tok_rd;
			lgs_pkg::ST_W_LD: begin
				b_q <= b_w;
				den_q <= den_w;
				num_q <= {a_w, 16'd0};
				rem_q <= '0;
				acc_q <= '0;
				cnt_q <= lgs_pkg::DIV_STEPS_M1;
			end
			lgs_pkg::ST_DIV: begin
				num_q <= {num_q[50:0], step_res.q_bit};
				rem_q <= step_res.rem;
				cnt_q <= (cnt_q == 6'd0) ? lgs_pkg::DIV_STEPS_M1 : cnt_q - 6'd1;
			end
			lgs_pkg::ST_MUL: begin
				num_q <= {num_q[50:0], 1'b0};
				acc_q <= step_res.acc;
				cnt_q <= cnt_q - 6'd1;
			end
			lgs_pkg::ST_W_ACC: begin
				total_q <= total_next;
				k_q <= k_last ? 7'd0 : k_q + 7'd1;
				acc_q <= '0;
				cnt_q <= lgs_pkg::FRAC_STEPS_M1;
			end
			lgs_pkg::ST_FRAC: begin
				acc_q <= step_res.acc;
				frac_q <= {1'b0, frac_q[31:1]};
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0 && op_q == lgs_pkg::OP_INIT) begin
					topic_q <= step_res.acc[5:0];
				end
			end
			lgs_pkg::ST_SCAN_CMP: begin
				// Clamping to the last topic covers overshoot and a zero total.
				if (hit || k_last) begin
					topic_q <= k_q[5:0];
				end else begin
					k_q <= k_q + 7'd1;
				end
			end
			lgs_pkg::ST_DONE: begin
				// The output register only takes the new topic once the old
				// result has been read.
				if (out_free) begin
					m_topic_q <= topic_q;
				end
			end
			default: begin
			end
		endcase
	end

	// Count memory access: clearing pass, decrement of the old topic, and
	// increment of the new one share the same ports.
	assign clearing = (state_q == lgs_pkg::ST_CLEAR);
	assign up       = (state_q == lgs_pkg::ST_INC_WR);
	assign upd_we   = (state_q == lgs_pkg::ST_DEC_WR) || up;
	assign rd_topic = (state_q == lgs_pkg::ST_W_RD) ? k_q[5:0] : topic_q;

	always_comb begin
		twc_we = clearing || upd_we;
		dtc_we = (clearing && clr_q[19:16] == 4'd0) || upd_we;
		dt_we  = (clearing && clr_q[19:10] == 10'd0) || upd_we;
		tt_we  = (clearing && clr_q[19:6] == 14'd0) || upd_we;
		twc_waddr = clearing ? clr_q : {topic_q, word_q};
		dtc_waddr = clearing ? clr_q[15:0] : {doc_q, topic_q};
		dt_waddr  = clearing ? clr_q[9:0] : doc_q;
		tt_waddr  = clearing ? clr_q[5:0] : topic_q;
		twc_wdata = clearing ? '0 : cnt_upd(twc_rd, up);
		dtc_wdata = clearing ? '0 : cnt_upd(dtc_rd, up);
		dt_wdata  = clearing ? '0 : cnt_upd(dt_rd, up);
		tt_wdata  = clearing ? '0 : cnt_upd(tt_rd, up);
	end

	lgs_ram #(.WIDTH(6), .DEPTH(lgs_pkg::MAX_TOKENS)) u_token_topic (
		.clk(clk), .we(up), .waddr(slot_q), .wdata(topic_q),
		.raddr(slot_q), .rdata(tok_rd)
	);

	lgs_ram #(.WIDTH(19), .DEPTH(lgs_pkg::TWC_DEPTH)) u_topic_word (
		.clk(clk), .we(twc_we), .waddr(twc_waddr), .wdata(twc_wdata),
		.raddr({rd_topic, word_q}), .rdata(twc_rd)
	);

	lgs_ram #(.WIDTH(19), .DEPTH(lgs_pkg::DTC_DEPTH)) u_doc_topic (
		.clk(clk), .we(dtc_we), .waddr(dtc_waddr), .wdata(dtc_wdata),
		.raddr({doc_q, rd_topic}), .rdata(dtc_rd)
	);

	lgs_ram #(.WIDTH(19), .DEPTH(lgs_pkg::MAX_DOCS)) u_doc_total (
		.clk(clk), .we(dt_we), .waddr(dt_waddr), .wdata(dt_wdata),
		.raddr(doc_q), .rdata(dt_rd)
	);

	lgs_ram #(.WIDTH(19), .DEPTH(lgs_pkg::MAX_TOPICS)) u_topic_total (
		.clk(clk), .we(tt_we), .waddr(tt_waddr), .wdata(tt_wdata),
		.raddr(rd_topic), .rdata(tt_rd)
	);

	lgs_ram #(.WIDTH(38), .DEPTH(lgs_pkg::MAX_TOPICS)) u_cum_weight (
		.clk(clk), .we(state_q == lgs_pkg::ST_W_ACC), .waddr(k_q[5:0]),
		.wdata(total_next), .raddr(k_q[5:0]), .rdata(cum_rd)
	);

	// A delivered topic is always one of the topics in use.
	a_topic_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (7'(m_topic_q) < k_use))
		else $error("result topic outside the topics in use");

	// The partial remainder of the ratio division stays below the divisor.
	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lgs_pkg::ST_DIV) |-> (rem_q < den_q))
		else $error("division remainder reached the divisor");

	// The multiply accumulator never passes its saturation value.
	a_acc_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lgs_pkg::ST_MUL) |=> (acc_q <= lgs_pkg::ACC_SAT))
		else $error("multiply accumulator beyond saturation");

endmodule

@@ design/lgs_ram.sv @@
// ----------------------------------------------------------------------------
// lgs_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lgs_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ design/lgs_step_unit.sv @@
// ----------------------------------------------------------------------------
// lgs_step_unit: shared bit-serial arithmetic step
// One adder serves a restoring divide step, a saturating shift-add multiply
// step and a shift-right accumulate step for fractional scaling.
// ----------------------------------------------------------------------------
module lgs_step_unit (
	input  lgs_pkg::step_req_t req,
	output lgs_pkg::step_res_t res
);

	logic [49:0] x;
	logic [49:0] y;
	logic        sub;
	logic [50:0] sum;
	logic [40:0] shifted;

	always_comb begin
		shifted = {req.rem, req.in_bit};
		x = '0;
		y = '0;
		sub = 1'b0;
		case (req.op)
			lgs_pkg::STEP_DIV: begin
				x = 50'(shifted);
				y = 50'(req.operand);
				sub = 1'b1;
			end
			lgs_pkg::STEP_MUL: begin
				x = {req.acc, 1'b0};
				y = req.in_bit ? 50'(req.operand) : '0;
			end
			lgs_pkg::STEP_RSH: begin
				x = 50'(req.acc);
				y = req.in_bit ? 50'(req.operand) : '0;
			end
			default: begin
			end
		endcase

		sum = {1'b0, x} + {1'b0, (sub ? ~y : y)} + 51'(sub);

		// For a divide step the carry out says the partial remainder covers
		// the divisor.
		res.q_bit = sum[50];
		res.rem = sum[50] ? sum[39:0] : shifted[39:0];

		case (req.op)
			lgs_pkg::STEP_MUL: res.acc = (sum[50:48] != 3'd0) ? lgs_pkg::ACC_SAT : sum[48:0];
			lgs_pkg::STEP_RSH: res.acc = sum[49:1];
			default:           res.acc = req.acc;
		endcase
	end

endmodule
